@@ design/lav_pkg.sv @@
// Shared types and constants for the look-at view matrix block.
// Depends on nothing; used by lav_front, lav_back and look_at_view_matrix.
`default_nettype none

package lav_pkg;

    // Default fraction bits of the Q format
    localparam int FRAC_BITS_DEF = 16;

    // Widths of a coordinate, a difference and a rescaled magnitude
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = 30;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Square-root work registers (sum of squares stays below 2^62)
    localparam int ROOT_W = 63;

    // One classified request as handed from front to back
    typedef struct packed {
        logic [2:0][COORD_W-1:0] eye;
        logic [2:0][DIFF_W-1:0]  dir;
        logic [2:0][COORD_W-1:0] up;
        logic                    dir_zero;
        logic                    up_zero;
    } t_job;

endpackage

`default_nettype wire

@@ design/lav_front.sv @@
// Front end: accepts requests, forms target - eye, flags zero vectors,
// and holds them in a short queue. Depends on lav_pkg.
`default_nettype none

module lav_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic signed [31:0]    i_eye_x,
    input  wire logic signed [31:0]    i_eye_y,
    input  wire logic signed [31:0]    i_eye_z,
    input  wire logic signed [31:0]    i_target_x,
    input  wire logic signed [31:0]    i_target_y,
    input  wire logic signed [31:0]    i_target_z,
    input  wire logic signed [31:0]    i_upvec_x,
    input  wire logic signed [31:0]    i_upvec_y,
    input  wire logic signed [31:0]    i_upvec_z,
    output lav_pkg::t_job              o_job,
    output logic                       o_job_valid,
    input  wire logic                  i_job_pop
);

    lav_pkg::t_job                   r_slot [lav_pkg::QUEUE_DEPTH];
    logic [lav_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [lav_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [lav_pkg::QPTR_W:0]        r_count;
    lav_pkg::t_job                   w_job;
    logic                            w_full;
    logic                            w_push;
    logic                            w_pop;

    // Classify the incoming request
    always_comb begin
        w_job.eye[0] = i_eye_x;
        w_job.eye[1] = i_eye_y;
        w_job.eye[2] = i_eye_z;
        w_job.up[0]  = i_upvec_x;
        w_job.up[1]  = i_upvec_y;
        w_job.up[2]  = i_upvec_z;
        w_job.dir[0] = {i_target_x[31], i_target_x} - {i_eye_x[31], i_eye_x};
        w_job.dir[1] = {i_target_y[31], i_target_y} - {i_eye_y[31], i_eye_y};
        w_job.dir[2] = {i_target_z[31], i_target_z} - {i_eye_z[31], i_eye_z};
        w_job.dir_zero = (i_target_x == i_eye_x) && (i_target_y == i_eye_y)
                         && (i_target_z == i_eye_z);
        w_job.up_zero  = (i_upvec_x == 32'sd0) && (i_upvec_y == 32'sd0)
                         && (i_upvec_z == 32'sd0);
    end

    assign w_full      = (r_count == (lav_pkg::QPTR_W + 1)'(lav_pkg::QUEUE_DEPTH));
    assign w_push      = i_in_valid && !w_full;
    assign w_pop       = i_job_pop && (r_count != '0);
    assign o_in_stall  = w_full;
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_slot[r_rd_ptr];

    // Advance the queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the request payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_job;
        end
    end

endmodule

`default_nettype wire

@@ design/lav_back.sv @@
// Back end: normalizes, forms cross and dot products with one shared multiplier,
// square-root and divide loops, and emits four rows. Depends on lav_pkg.
`default_nettype none

module lav_back #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  lav_pkg::t_job              i_job,
    input  wire logic                  i_job_valid,
    output logic                       o_job_pop,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [1:0]                 o_row_index,
    output logic signed [31:0]         o_col0,
    output logic signed [31:0]         o_col1,
    output logic signed [31:0]         o_col2,
    output logic signed [31:0]         o_col3,
    output logic                       o_error_flag,
    output logic                       o_last_row
);

    localparam int CW  = FRAC_BITS + 4;
    localparam int QW  = FRAC_BITS + 1;
    localparam int DCW = $clog2(FRAC_BITS + 1);
    localparam int MW  = lav_pkg::MAG_W;
    localparam int RW  = lav_pkg::ROOT_W;
    localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SCALE, S_SQ, S_SQRT, S_DIV, S_CRL, S_CRT, S_DOT, S_EMIT
    } t_state;

    t_state                r_state;
    logic signed [31:0]    r_eye [3];
    logic signed [32:0]    r_dir [3];
    logic signed [31:0]    r_up [3];
    logic                  r_dz;
    logic                  r_uz;
    logic                  r_vsel;
    logic                  r_err;
    logic [MW-1:0]         r_mag [3];
    logic                  r_neg [3];
    logic signed [63:0]    r_acc;
    logic signed [63:0]    r_prod;
    logic                  r_phase;
    logic [2:0]            r_op;
    logic [1:0]            r_row;
    logic [RW-1:0]         r_sq_n;
    logic [RW-1:0]         r_root;
    logic [RW-1:0]         r_bit;
    logic [31:0]           r_len;
    logic [32:0]           r_rem [3];
    logic [QW-1:0]         r_quo [3];
    logic [DCW-1:0]        r_dcnt;
    logic signed [CW-1:0]  r_fwd [3];
    logic signed [CW-1:0]  r_upn [3];
    logic signed [CW-1:0]  r_lft [3];
    logic signed [CW-1:0]  r_tup [3];
    logic signed [31:0]    r_col3 [3];
    logic                  r_out_valid;
    logic [1:0]            r_out_row;
    logic signed [31:0]    r_out_col [4];
    logic                  r_out_err;
    logic                  r_out_last;

    logic signed [32:0]    w_vec [3];
    logic                  w_neg [3];
    logic [32:0]           w_abs [3];
    logic [32:0]           w_max;
    logic [5:0]            w_msb;
    logic [MW-1:0]         w_scaled [3];
    logic                  w_vzero;
    logic [3:0]            w_pick;
    logic signed [31:0]    w_ma;
    logic signed [31:0]    w_mb;
    logic signed [63:0]    w_prod;
    logic signed [63:0]    w_sum;
    logic signed [63:0]    w_diff;
    logic signed [CW-1:0]  w_crs;
    logic [RW-1:0]         w_trial;
    logic [32:0]           w_rem_sub [3];
    logic [QW-1:0]         w_quo [3];
    logic signed [CW-1:0]  w_unit [3];
    logic signed [CW-1:0]  w_rowv [3];
    logic signed [63:0]    w_neg_s;
    logic signed [63:0]    w_t;
    logic signed [31:0]    w_col3;
    logic                  w_sat;
    logic                  w_load;

    // Operand indices of the two products of one cross component
    function automatic logic [3:0] cross_pick(input logic [2:0] op);
        logic [3:0] pick;
        unique case (op)
            3'd0:    pick = {2'd1, 2'd2};
            3'd1:    pick = {2'd2, 2'd1};
            3'd2:    pick = {2'd2, 2'd0};
            3'd3:    pick = {2'd0, 2'd2};
            3'd4:    pick = {2'd0, 2'd1};
            3'd5:    pick = {2'd1, 2'd0};
            default: pick = 4'd0;
        endcase
        return pick;
    endfunction

    // Rescale the selected vector so its largest magnitude lies in [2^29, 2^30)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_vec[k] = r_vsel ? {r_up[k][31], r_up[k]} : r_dir[k];
            w_neg[k] = w_vec[k][32];
            w_abs[k] = w_neg[k] ? (33'd0 - w_vec[k]) : w_vec[k];
        end
        w_max = w_abs[0];
        if (w_abs[1] > w_max) begin
            w_max = w_abs[1];
        end
        if (w_abs[2] > w_max) begin
            w_max = w_abs[2];
        end
        w_msb = 6'd0;
        for (int b = 0; b < 33; b++) begin
            if (w_max[b]) begin
                w_msb = 6'(b);
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (w_msb >= 6'd29) begin
                w_scaled[k] = MW'(w_abs[k] >> (w_msb - 6'd29));
            end else begin
                w_scaled[k] = MW'(w_abs[k] << (6'd29 - w_msb));
            end
        end
        w_vzero = r_vsel ? r_uz : r_dz;
    end

    // Select the current row of the rotation part
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (r_row)
                2'd0:    w_rowv[k] = r_lft[k];
                2'd1:    w_rowv[k] = r_tup[k];
                2'd2:    w_rowv[k] = -r_fwd[k];
                default: w_rowv[k] = '0;
            endcase
        end
    end

    // Feed the shared multiplier
    always_comb begin
        w_pick = cross_pick(r_op);
        w_ma   = '0;
        w_mb   = '0;
        case (r_state)
            S_SQ: begin
                w_ma = $signed({2'b00, r_mag[r_op[1:0]]});
                w_mb = w_ma;
            end
            S_CRL: begin
                w_ma = 32'(r_fwd[w_pick[3:2]]);
                w_mb = 32'(r_upn[w_pick[1:0]]);
            end
            S_CRT: begin
                w_ma = 32'(r_lft[w_pick[3:2]]);
                w_mb = 32'(r_fwd[w_pick[1:0]]);
            end
            S_DOT: begin
                w_ma = 32'(w_rowv[r_op[1:0]]);
                w_mb = r_eye[r_op[1:0]];
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    // Accumulate, cross difference and saturated translation term
    always_comb begin
        w_sum   = r_acc + r_prod;
        w_diff  = r_acc - r_prod;
        w_crs   = CW'(w_diff >>> FRAC_BITS);
        w_neg_s = -w_sum;
        w_t     = w_neg_s >>> FRAC_BITS;
        w_sat   = (w_t[63:31] != {33{w_t[63]}});
        if (!w_sat) begin
            w_col3 = w_t[31:0];
        end else if (w_t[63]) begin
            w_col3 = 32'sh8000_0000;
        end else begin
            w_col3 = 32'sh7FFF_FFFF;
        end
        w_trial = r_root + r_bit;
    end

    // One restoring divide step per lane
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_quo[k]     = {r_quo[k][QW-2:0], (r_rem[k] >= {1'b0, r_len})};
            w_rem_sub[k] = w_quo[k][0] ? (r_rem[k] - {1'b0, r_len}) : r_rem[k];
            w_unit[k]    = r_neg[k] ? -CW'(w_quo[k]) : CW'(w_quo[k]);
        end
    end

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign w_load    = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    // Sequence one request and hold the output row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_op        <= '0;
            r_row       <= '0;
            r_vsel      <= 1'b0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        for (int k = 0; k < 3; k++) begin
                            r_eye[k] <= $signed(i_job.eye[k]);
                            r_dir[k] <= $signed(i_job.dir[k]);
                            r_up[k]  <= $signed(i_job.up[k]);
                        end
                        r_dz    <= i_job.dir_zero;
                        r_uz    <= i_job.up_zero;
                        r_vsel  <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (w_vzero) begin
                        for (int k = 0; k < 3; k++) begin
                            if (r_vsel) begin
                                r_upn[k] <= '0;
                            end else begin
                                r_fwd[k] <= '0;
                            end
                        end
                        r_err <= 1'b1;
                        if (r_vsel) begin
                            r_op    <= '0;
                            r_phase <= 1'b0;
                            r_state <= S_CRL;
                        end else begin
                            r_vsel <= 1'b1;
                        end
                    end else begin
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= w_scaled[k];
                            r_neg[k] <= w_neg[k];
                        end
                        r_acc   <= '0;
                        r_op    <= '0;
                        r_phase <= 1'b0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (!r_phase) begin
                        r_prod  <= w_prod;
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        r_acc   <= w_sum;
                        if (r_op == 3'd2) begin
                            r_sq_n  <= RW'(w_sum);
                            r_root  <= '0;
                            r_bit   <= {1'b1, {(RW - 1){1'b0}}};
                            r_state <= S_SQRT;
                        end else begin
                            r_op <= r_op + 3'd1;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_bit != '0) begin
                        if (r_sq_n >= w_trial) begin
                            r_sq_n <= r_sq_n - w_trial;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_len <= r_root[31:0];
                        for (int k = 0; k < 3; k++) begin
                            r_rem[k] <= {3'b000, r_mag[k]};
                        end
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    for (int k = 0; k < 3; k++) begin
                        r_rem[k] <= {w_rem_sub[k][31:0], 1'b0};
                        r_quo[k] <= w_quo[k];
                    end
                    if (r_dcnt == DCW'(FRAC_BITS)) begin
                        for (int k = 0; k < 3; k++) begin
                            if (r_vsel) begin
                                r_upn[k] <= w_unit[k];
                            end else begin
                                r_fwd[k] <= w_unit[k];
                            end
                        end
                        if (r_vsel) begin
                            r_op    <= '0;
                            r_phase <= 1'b0;
                            r_state <= S_CRL;
                        end else begin
                            r_vsel  <= 1'b1;
                            r_state <= S_SCALE;
                        end
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_CRL, S_CRT: begin
                    if (!r_phase) begin
                        r_prod  <= w_prod;
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        if (!r_op[0]) begin
                            r_acc <= r_prod;
                        end else if (r_state == S_CRL) begin
                            r_lft[r_op[2:1]] <= w_crs;
                        end else begin
                            r_tup[r_op[2:1]] <= w_crs;
                        end
                        if (r_op == 3'd5) begin
                            r_op <= '0;
                            if (r_state == S_CRL) begin
                                r_state <= S_CRT;
                            end else begin
                                r_acc   <= '0;
                                r_row   <= '0;
                                r_state <= S_DOT;
                            end
                        end else begin
                            r_op <= r_op + 3'd1;
                        end
                    end
                end
                S_DOT: begin
                    if (!r_phase) begin
                        r_prod  <= w_prod;
                        r_phase <= 1'b1;
                    end else begin
                        r_phase <= 1'b0;
                        if (r_op == 3'd2) begin
                            r_col3[r_row] <= w_col3;
                            if (w_sat) begin
                                r_err <= 1'b1;
                            end
                            r_acc <= '0;
                            r_op  <= '0;
                            if (r_row == 2'd2) begin
                                r_row   <= '0;
                                r_state <= S_EMIT;
                            end else begin
                                r_row <= r_row + 2'd1;
                            end
                        end else begin
                            r_acc <= w_sum;
                            r_op  <= r_op + 3'd1;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out_row  <= r_row;
                        r_out_err  <= r_err;
                        r_out_last <= (r_row == 2'd3);
                        if (r_row == 2'd3) begin
                            r_out_col[0] <= '0;
                            r_out_col[1] <= '0;
                            r_out_col[2] <= '0;
                            r_out_col[3] <= $signed(ONE_Q);
                            r_state      <= S_IDLE;
                        end else begin
                            for (int k = 0; k < 3; k++) begin
                                r_out_col[k] <= 32'(w_rowv[k]);
                            end
                            r_out_col[3] <= r_col3[r_row];
                            r_row        <= r_row + 2'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_index  = r_out_row;
    assign o_col0       = r_out_col[0];
    assign o_col1       = r_out_col[1];
    assign o_col2       = r_out_col[2];
    assign o_col3       = r_out_col[3];
    assign o_error_flag = r_out_err;
    assign o_last_row   = r_out_last;

endmodule

`default_nettype wire

@@ design/look_at_view_matrix.sv @@
// Look-at view matrix builder, top level: front end with request queue and back end.
// Depends on lav_pkg, lav_front and lav_back.
//
//   channel | valid       | stall        | payload
//   input   | i_in_valid  | o_in_stall   | i_eye_*, i_target_*, i_upvec_*
//   output  | o_out_valid | i_out_stall  | o_row_index, o_col0..3, o_error_flag, o_last_row
//
// The back end's time on a request, without output stall, is set by the bit-serial square root
// and divide, run once per vector, and by the one shared multiplier.
// Zero-length vectors skip their square root and divide. Four rows follow per request.
// Reset is synchronous and active low; it empties the queue and idles the sequencer.
// The two-entry queue takes requests until full while the back end waits on output stall.
`default_nettype none

module look_at_view_matrix #(
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [31:0] i_eye_x,
    input  wire logic signed [31:0] i_eye_y,
    input  wire logic signed [31:0] i_eye_z,
    input  wire logic signed [31:0] i_target_x,
    input  wire logic signed [31:0] i_target_y,
    input  wire logic signed [31:0] i_target_z,
    input  wire logic signed [31:0] i_upvec_x,
    input  wire logic signed [31:0] i_upvec_y,
    input  wire logic signed [31:0] i_upvec_z,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_row_index,
    output logic signed [31:0]      o_col0,
    output logic signed [31:0]      o_col1,
    output logic signed [31:0]      o_col2,
    output logic signed [31:0]      o_col3,
    output logic                    o_error_flag,
    output logic                    o_last_row
);

    lav_pkg::t_job w_job;
    logic          w_job_valid;
    logic          w_job_pop;

    // Accept and classify requests
    lav_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_eye_x     (i_eye_x),
        .i_eye_y     (i_eye_y),
        .i_eye_z     (i_eye_z),
        .i_target_x  (i_target_x),
        .i_target_y  (i_target_y),
        .i_target_z  (i_target_z),
        .i_upvec_x   (i_upvec_x),
        .i_upvec_y   (i_upvec_y),
        .i_upvec_z   (i_upvec_z),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_pop   (w_job_pop)
    );

    // Build the matrix rows
    lav_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_job),
        .i_job_valid  (w_job_valid),
        .o_job_pop    (w_job_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_row_index  (o_row_index),
        .o_col0       (o_col0),
        .o_col1       (o_col1),
        .o_col2       (o_col2),
        .o_col3       (o_col3),
        .o_error_flag (o_error_flag),
        .o_last_row   (o_last_row)
    );

`ifndef SYNTHESIS
    // Last-row marker and row index agree
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_row == (o_row_index == 2'd3)))
        else $error("last_row does not match row index");

    // Fourth row is the constant homogeneous row
    a_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_row) |-> ((o_col0 == 32'sd0) && (o_col1 == 32'sd0)
            && (o_col2 == 32'sd0) && (o_col3 == $signed(32'd1 << FRAC_BITS))))
        else $error("fourth row is not 0,0,0,1");

    // Rows of one request follow without a gap
    a_row_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_row) |=>
            (o_out_valid && (o_row_index == $past(o_row_index) + 2'd1)))
        else $error("row sequence broken");

    // Error flag is the same on all rows of a request
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_row) |=>
            (o_error_flag == $past(o_error_flag)))
        else $error("error flag changed within a request");
`endif

endmodule

`default_nettype wire
